// ===== rtl/imrt_pkg.sv =====
package imrt_pkg;

   localparam int ENTRIES_DEF    = 64;
   localparam int KEY_BITS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 8;

   // fixed field widths of the result and register ports
   localparam int FOUND_W  = 8;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 7;
   localparam int CSR_W    = 8;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_ASSIGN = 1'b1;

   typedef struct packed {
      logic start;
      logic push;
   } emit_ctl_type;

endpackage

// ===== rtl/imrt_req_if.sv =====
interface imrt_req_if #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [KEY_BITS-1:0]   key_begin;
   logic [KEY_BITS-1:0]   key_end;
   logic [VALUE_BITS-1:0] new_value;

   modport source (output valid, func, key_begin, key_end, new_value, input ready);
   modport sink   (input valid, func, key_begin, key_end, new_value, output ready);
endinterface

// ===== rtl/imrt_rsp_if.sv =====
interface imrt_rsp_if;
   import imrt_pkg::*;
   logic                valid;
   logic                ready;
   logic [FOUND_W-1:0]  found_value;
   logic [STATUS_W-1:0] status;
   logic [USED_W-1:0]   entries_used;

   modport source (output valid, found_value, status, entries_used, input ready);
   modport sink   (input valid, found_value, status, entries_used, output ready);
endinterface

// ===== rtl/interval_map_range_table.sv =====
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | func, key_begin, key_end, new_value
// rsp     | out | valid/ready   | found_value, status, entries_used
// csr     | in  | csr_we        | csr_wdata (default value)
//
// With n breakpoints held, a lookup scans all n before its result goes valid; an assign
// scans them, pushes its two range breakpoints mid-scan and copies any past the range; an
// empty-range assign needs no scan. The next request can transfer in the cycle the result
// goes valid. The scan reads one bank entry per cycle, paused while those are pushed.
// Assigns rebuild the table into the other of two banks and swap on success.
// Reset empties the table and clears the default value; the bank RAMs keep their data.
// A held result does not block the next request; a new result waits for rsp.
module interval_map_range_table #(
   parameter int ENTRIES    = imrt_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = imrt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = imrt_pkg::VALUE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   imrt_req_if.sink                   req,
   imrt_rsp_if.source                 rsp,
   input  logic                       csr_we,
   input  logic [imrt_pkg::CSR_W-1:0] csr_wdata
);
   import imrt_pkg::*;

   localparam int AW  = $clog2(ENTRIES);
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int KCW = $clog2(ENTRIES + 3);
   localparam int DW  = KEY_BITS + VALUE_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_SCAN1 = 3'd2;
   localparam logic [2:0] ST_BEGIN = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;
   localparam logic [2:0] ST_SCAN2 = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [KEY_BITS-1:0]   kb_ff, kb_in, ke_ff, ke_in;
   logic [VALUE_BITS-1:0] nv_ff, nv_in, lv_ff, lv_in, dflt_ff, dflt_in;
   logic [CW-1:0]         count_ff, count_in, rd_idx_ff, rd_idx_in, pend_idx_ff, pend_idx_in;
   logic                  pend_ff, pend_in, bank_ff, bank_in;
   logic [VALUE_BITS-1:0] found_ff, found_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FOUND_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [USED_W-1:0]     rsp_used_ff, rsp_used_in;

   logic                  scanning, issue, scan_end, req_xfer;
   logic [DW-1:0]         rdata0, rdata1, rdata;
   logic [KEY_BITS-1:0]   rkey;
   logic [VALUE_BITS-1:0] rval;
   logic [63:0]           csr_ext, found_ext;
   logic [31:0]           used_ext;

   emit_ctl_type          ectl;
   logic [KEY_BITS-1:0]   push_key;
   logic [VALUE_BITS-1:0] push_val;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic [KCW-1:0]        kept;

   assign req_xfer = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   assign scanning = (state_ff == ST_LOOK) || (state_ff == ST_SCAN1) ||
                     (state_ff == ST_SCAN2);
   assign issue    = scanning && (rd_idx_ff < count_ff);
   assign scan_end = !issue && !pend_ff;

   assign rdata = bank_ff ? rdata1 : rdata0;
   assign rkey  = rdata[DW-1:VALUE_BITS];
   assign rval  = rdata[VALUE_BITS-1:0];

   assign csr_ext   = 64'(csr_wdata);
   assign found_ext = 64'(found_ff);
   assign used_ext  = 32'(count_ff);

   always_comb begin
      state_in    = state_ff;
      kb_in       = kb_ff;
      ke_in       = ke_ff;
      nv_in       = nv_ff;
      lv_in       = lv_ff;
      count_in    = count_ff;
      bank_in     = bank_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      rd_idx_in   = issue ? rd_idx_ff + 1'b1 : rd_idx_ff;
      pend_in     = issue;
      pend_idx_in = rd_idx_ff;
      ectl        = '0;
      push_key    = rkey;
      push_val    = rval;
      dflt_in     = csr_we ? csr_ext[VALUE_BITS-1:0] : dflt_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kb_in     = req.key_begin;
               ke_in     = req.key_end;
               nv_in     = req.new_value;
               lv_in     = dflt_ff;
               rd_idx_in = '0;
               found_in  = '0;
               status_in = STATUS_DONE;
               if (req.func == FUNC_LOOKUP) begin
                  state_in = ST_LOOK;
               end else if (!(req.key_begin < req.key_end)) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_DONE;
               end else begin
                  ectl.start = 1'b1;
                  state_in   = ST_SCAN1;
               end
            end
         end
         ST_LOOK: begin
            if (pend_ff && (rkey <= kb_ff)) begin
               lv_in = rval;
            end
            if (scan_end) begin
               found_in = lv_ff;
               state_in = ST_DONE;
            end
         end
         ST_SCAN1: begin
            if (pend_ff) begin
               if (rkey < kb_ff) begin
                  ectl.push = 1'b1;
                  lv_in     = rval;
               end else if (rkey <= ke_ff) begin
                  lv_in = rval;
               end else begin
                  // first entry past the range: drop the read in flight, resume here
                  rd_idx_in = pend_idx_ff;
                  pend_in   = 1'b0;
                  state_in  = ST_BEGIN;
               end
            end else if (scan_end) begin
               state_in = ST_BEGIN;
            end
         end
         ST_BEGIN: begin
            ectl.push = 1'b1;
            push_key  = kb_ff;
            push_val  = nv_ff;
            state_in  = ST_END;
         end
         ST_END: begin
            ectl.push = 1'b1;
            push_key  = ke_ff;
            push_val  = lv_ff;
            state_in  = ST_SCAN2;
         end
         ST_SCAN2: begin
            ectl.push = pend_ff;
            if (scan_end) begin
               if (kept > KCW'(ENTRIES)) begin
                  status_in = STATUS_FULL;
               end else begin
                  bank_in  = !bank_ff;
                  count_in = CW'(kept);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ext[FOUND_W-1:0];
               rsp_status_in = status_ff;
               rsp_used_in   = used_ext[USED_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         dflt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         pend_ff      <= pend_in;
         rd_idx_ff    <= rd_idx_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kb_ff         <= kb_in;
      ke_ff         <= ke_in;
      nv_ff         <= nv_in;
      lv_ff         <= lv_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found_value  = rsp_found_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.entries_used = rsp_used_ff;

   imrt_emit #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .AW        (AW),
      .KCW       (KCW)
   ) u_emit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ectl),
      .dflt    (dflt_ff),
      .push_key(push_key),
      .push_val(push_val),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .kept    (kept)
   );

   // read the active bank, rebuild into the other one
   imrt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_bank0 (
      .clock  (clock),
      .wr_en  (wr_en && bank_ff),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(rdata0)
   );

   imrt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_bank1 (
      .clock  (clock),
      .wr_en  (wr_en && !bank_ff),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(rdata1)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("request transfer did not start a sequence");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("breakpoint count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN2 && scan_end && kept > KCW'(ENTRIES)) |=> $stable(bank_ff))
      else $error("rejected assign swapped the bank");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BEGIN || state_ff == ST_END || state_ff == ST_DONE) |-> !pend_ff)
      else $error("read in flight outside a scan");
endmodule

// ===== rtl/imrt_ram.sv =====
module imrt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/imrt_emit.sv =====
module imrt_emit #(
   parameter int ENTRIES    = 64,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 8,
   parameter int AW         = $clog2(ENTRIES),
   parameter int KCW        = $clog2(ENTRIES + 3)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  imrt_pkg::emit_ctl_type       ctl,
   input  logic [VALUE_BITS-1:0]        dflt,
   input  logic [KEY_BITS-1:0]          push_key,
   input  logic [VALUE_BITS-1:0]        push_val,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [KEY_BITS+VALUE_BITS-1:0] wr_data,
   output logic [KCW-1:0]               kept
);
   import imrt_pkg::*;

   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [KCW-1:0]        wcnt_ff, wcnt_in;
   logic                  keep;

   // keep only breakpoints that change the value in effect
   assign keep    = ctl.push && (push_val != prev_ff);
   assign wr_en   = keep && (wcnt_ff < KCW'(ENTRIES));
   assign wr_addr = wcnt_ff[AW-1:0];
   assign wr_data = {push_key, push_val};
   assign kept    = wcnt_ff;

   always_comb begin
      prev_in = prev_ff;
      wcnt_in = wcnt_ff;
      if (ctl.start) begin
         prev_in = dflt;
         wcnt_in = '0;
      end else if (keep) begin
         prev_in = push_val;
         wcnt_in = wcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= '0;
      end else begin
         wcnt_ff <= wcnt_in;
      end
      prev_ff <= prev_in;
   end
endmodule
